// ===== src/sbcs_pkg.sv =====
// Package: shared types, codes and widths for the shell-binned correlation sums block.
package sbcs_pkg;

  localparam int unsigned NUM_BINS_DEF = 25;

  localparam int unsigned PIX_W   = 16;
  localparam int unsigned OFS_W   = 14;
  localparam int unsigned SEL_W   = 5;
  localparam int unsigned BOX_W   = 7;
  localparam int unsigned SHW_W   = 12;
  localparam int unsigned TOT_W   = 28;
  localparam int unsigned USED_W  = 13;
  localparam int unsigned AVG_W   = 24;
  localparam int unsigned CNT_W   = 24;
  localparam int unsigned SUM_W   = 48;
  localparam int unsigned SQ_W    = 64;
  localparam int unsigned DVD_W   = TOT_W + 8;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 16;

  typedef enum logic [1:0] {
    ACT_PAIR  = 2'd0,
    ACT_READ  = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BOX_SIZE    = 3'd0,
    REG_SHELL_WIDTH = 3'd1,
    REG_OVL_FIRST   = 3'd2,
    REG_IGN_FIRST   = 3'd3,
    REG_OVL_SECOND  = 3'd4,
    REG_IGN_SECOND  = 3'd5
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_STEP,
    ST_MUL_ROW,
    ST_MUL_COL,
    ST_SHELL,
    ST_DIV,
    ST_SQ_A,
    ST_SQ_B,
    ST_SQ_C,
    ST_UPDATE
  } state_e;

  typedef struct packed {
    logic mul_step;
    logic mul_row;
    logic mul_col;
    logic shell_step;
    logic div_step;
    logic sq_a;
    logic sq_b;
    logic sq_c;
    logic update;
    logic busy;
  } cmd_t;

  typedef struct packed {
    logic fin_go;
    logic shell_hit;
    logic shell_over;
    logic div_last;
  } stat_t;

endpackage

// ===== src/sbcs_ctrl.sv =====
// Controller: sequences the chunk finish (multiplies, shell search, divide, squares, bin update).
module sbcs_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  sbcs_pkg::stat_t stat_i,
  output sbcs_pkg::cmd_t  cmd_o
);

  sbcs_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sbcs_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sbcs_pkg::ST_IDLE: begin
        if (stat_i.fin_go) state_d = sbcs_pkg::ST_MUL_STEP;
      end
      sbcs_pkg::ST_MUL_STEP: state_d = sbcs_pkg::ST_MUL_ROW;
      sbcs_pkg::ST_MUL_ROW:  state_d = sbcs_pkg::ST_MUL_COL;
      sbcs_pkg::ST_MUL_COL:  state_d = sbcs_pkg::ST_SHELL;
      sbcs_pkg::ST_SHELL: begin
        if (stat_i.shell_hit) state_d = sbcs_pkg::ST_DIV;
        else if (stat_i.shell_over) state_d = sbcs_pkg::ST_IDLE;
      end
      sbcs_pkg::ST_DIV: begin
        if (stat_i.div_last) state_d = sbcs_pkg::ST_SQ_A;
      end
      sbcs_pkg::ST_SQ_A:  state_d = sbcs_pkg::ST_SQ_B;
      sbcs_pkg::ST_SQ_B:  state_d = sbcs_pkg::ST_SQ_C;
      sbcs_pkg::ST_SQ_C:  state_d = sbcs_pkg::ST_UPDATE;
      sbcs_pkg::ST_UPDATE: state_d = sbcs_pkg::ST_IDLE;
      default: state_d = sbcs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.busy = (state_q != sbcs_pkg::ST_IDLE);
    unique case (state_q)
      sbcs_pkg::ST_MUL_STEP: cmd_o.mul_step   = 1'b1;
      sbcs_pkg::ST_MUL_ROW:  cmd_o.mul_row    = 1'b1;
      sbcs_pkg::ST_MUL_COL:  cmd_o.mul_col    = 1'b1;
      sbcs_pkg::ST_SHELL:    cmd_o.shell_step = 1'b1;
      sbcs_pkg::ST_DIV:      cmd_o.div_step   = 1'b1;
      sbcs_pkg::ST_SQ_A:     cmd_o.sq_a       = 1'b1;
      sbcs_pkg::ST_SQ_B:     cmd_o.sq_b       = 1'b1;
      sbcs_pkg::ST_SQ_C:     cmd_o.sq_c       = 1'b1;
      sbcs_pkg::ST_UPDATE:   cmd_o.update     = 1'b1;
      default: ;
    endcase
  end

endmodule

// ===== src/sbcs_dp.sv =====
// Datapath: config registers, chunk accumulators, radius, shell search, dividers, bins, read port.
module sbcs_dp #(
  parameter int unsigned NUM_BINS = sbcs_pkg::NUM_BINS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              accept_i,
  input  logic [1:0]                        action_i,
  input  logic [sbcs_pkg::PIX_W-1:0]        pixel_first_i,
  input  logic [sbcs_pkg::PIX_W-1:0]        pixel_second_i,
  input  logic                              inside_first_i,
  input  logic                              inside_second_i,
  input  logic signed [sbcs_pkg::OFS_W-1:0] chunk_row_offset_i,
  input  logic signed [sbcs_pkg::OFS_W-1:0] chunk_col_offset_i,
  input  logic                              chunk_end_i,
  input  logic [sbcs_pkg::SEL_W-1:0]        bin_select_i,
  input  logic                              cfg_we_i,
  input  logic [sbcs_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [sbcs_pkg::CFG_DAT_W-1:0]    cfg_data_i,
  input  sbcs_pkg::cmd_t                    cmd_i,
  output sbcs_pkg::stat_t                   stat_o,
  output logic                              done_o,
  output logic [sbcs_pkg::CNT_W-1:0]        pair_count_o,
  output logic [sbcs_pkg::SUM_W-1:0]        sum_first_o,
  output logic [sbcs_pkg::SUM_W-1:0]        sum_second_o,
  output logic [sbcs_pkg::SQ_W-1:0]         sum_sq_first_o,
  output logic [sbcs_pkg::SQ_W-1:0]         sum_sq_second_o,
  output logic [sbcs_pkg::SQ_W-1:0]         sum_cross_o
);

  localparam int unsigned KW    = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int unsigned SQW   = 2 * (sbcs_pkg::SHW_W + 1 + $clog2(NUM_BINS + 1));
  localparam int unsigned R2W   = 31;
  localparam int unsigned CMPW  = ((SQW > R2W) ? SQW : R2W) + 1;
  localparam int unsigned STW   = sbcs_pkg::SHW_W + 1;
  localparam int unsigned DCW   = $clog2(sbcs_pkg::DVD_W);
  localparam logic [KW-1:0] LAST_K = KW'(NUM_BINS - 1);

  localparam logic [sbcs_pkg::TOT_W-1:0]  TOT_MAX  = '1;
  localparam logic [sbcs_pkg::USED_W-1:0] USED_MAX = '1;
  localparam logic [sbcs_pkg::CNT_W-1:0]  CNT_MAX  = '1;
  localparam logic [sbcs_pkg::SUM_W-1:0]  SUM_MAX  = '1;
  localparam logic [sbcs_pkg::SQ_W-1:0]   SQ_MAX   = '1;
  localparam logic [sbcs_pkg::AVG_W-1:0]  AVG_MAX  = '1;

  // config
  logic [sbcs_pkg::BOX_W-1:0] box_q;
  logic [sbcs_pkg::SHW_W-1:0] shw_q;
  logic [sbcs_pkg::PIX_W-1:0] ovl1_q, ign1_q, ovl2_q, ign2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_q  <= sbcs_pkg::BOX_W'(8);
      shw_q  <= sbcs_pkg::SHW_W'(50);
      ovl1_q <= 16'hFFFF;
      ign1_q <= 16'hFFFE;
      ovl2_q <= 16'hFFFF;
      ign2_q <= 16'hFFFE;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        sbcs_pkg::REG_BOX_SIZE:    box_q  <= cfg_data_i[sbcs_pkg::BOX_W-1:0];
        sbcs_pkg::REG_SHELL_WIDTH: shw_q  <= cfg_data_i[sbcs_pkg::SHW_W-1:0];
        sbcs_pkg::REG_OVL_FIRST:   ovl1_q <= cfg_data_i;
        sbcs_pkg::REG_IGN_FIRST:   ign1_q <= cfg_data_i;
        sbcs_pkg::REG_OVL_SECOND:  ovl2_q <= cfg_data_i;
        sbcs_pkg::REG_IGN_SECOND:  ign2_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // chunk accumulators
  logic [sbcs_pkg::TOT_W-1:0]  tot1_q, tot2_q, tot1_n, tot2_n;
  logic [sbcs_pkg::USED_W-1:0] used1_q, used2_q, used1_n, used2_n;
  logic [sbcs_pkg::TOT_W:0]    tsum1, tsum2;
  logic keep1, keep2, pair_acc, chunk_fin;

  assign pair_acc  = accept_i && (action_i == sbcs_pkg::ACT_PAIR);
  assign chunk_fin = pair_acc && chunk_end_i;
  assign keep1 = inside_first_i && (pixel_first_i != ovl1_q) && (pixel_first_i != ign1_q);
  assign keep2 = inside_second_i && (pixel_second_i != ovl2_q) && (pixel_second_i != ign2_q);
  assign tsum1 = {1'b0, tot1_q} + (sbcs_pkg::TOT_W + 1)'(pixel_first_i);
  assign tsum2 = {1'b0, tot2_q} + (sbcs_pkg::TOT_W + 1)'(pixel_second_i);

  always_comb begin
    tot1_n = tot1_q;
    used1_n = used1_q;
    tot2_n = tot2_q;
    used2_n = used2_q;
    if (keep1) begin
      tot1_n  = tsum1[sbcs_pkg::TOT_W] ? TOT_MAX : tsum1[sbcs_pkg::TOT_W-1:0];
      used1_n = (used1_q == USED_MAX) ? USED_MAX : used1_q + 1'b1;
    end
    if (keep2) begin
      tot2_n  = tsum2[sbcs_pkg::TOT_W] ? TOT_MAX : tsum2[sbcs_pkg::TOT_W-1:0];
      used2_n = (used2_q == USED_MAX) ? USED_MAX : used2_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tot1_q <= '0; used1_q <= '0; tot2_q <= '0; used2_q <= '0;
    end else if (pair_acc) begin
      if (chunk_end_i) begin
        tot1_q <= '0; used1_q <= '0; tot2_q <= '0; used2_q <= '0;
      end else begin
        tot1_q <= tot1_n; used1_q <= used1_n; tot2_q <= tot2_n; used2_q <= used2_n;
      end
    end
  end

  assign stat_o.fin_go = chunk_fin && (used1_n != '0) && (used2_n != '0) && (shw_q != '0);

  // radius terms at chunk end
  logic signed [16:0] dr, dc;
  logic [16:0] dr_abs, dc_abs;
  logic [14:0] ar_q, ac_q;
  logic [29:0] sqr_q, sqc_q;
  logic [R2W-1:0] r2;

  assign dr = {{2{chunk_row_offset_i[sbcs_pkg::OFS_W-1]}}, chunk_row_offset_i, 1'b0}
            + {10'd0, box_q} - 17'sd1;
  assign dc = {{2{chunk_col_offset_i[sbcs_pkg::OFS_W-1]}}, chunk_col_offset_i, 1'b0}
            + {10'd0, box_q} - 17'sd1;
  assign dr_abs = dr[16] ? 17'(-dr) : 17'(dr);
  assign dc_abs = dc[16] ? 17'(-dc) : 17'(dc);
  assign r2 = {1'b0, sqr_q} + {1'b0, sqc_q};

  // divider operands
  logic [sbcs_pkg::DVD_W-1:0]  dvd1_q, dvd2_q;
  logic [sbcs_pkg::USED_W-1:0] dvs1_q, dvs2_q;
  logic [sbcs_pkg::USED_W:0]   rem1_q, rem2_q, rsh1, rsh2;
  logic [DCW-1:0]              dcnt_q;

  always_ff @(posedge clk_i) begin
    if (stat_o.fin_go) begin
      ar_q   <= dr_abs[14:0];
      ac_q   <= dc_abs[14:0];
      dvd1_q <= {tot1_n, 8'd0};
      dvd2_q <= {tot2_n, 8'd0};
      dvs1_q <= used1_n;
      dvs2_q <= used2_n;
      rem1_q <= '0;
      rem2_q <= '0;
      dcnt_q <= DCW'(sbcs_pkg::DVD_W - 1);
    end else if (cmd_i.div_step) begin
      dvd1_q <= {dvd1_q[sbcs_pkg::DVD_W-2:0], (rsh1 >= {1'b0, dvs1_q})};
      dvd2_q <= {dvd2_q[sbcs_pkg::DVD_W-2:0], (rsh2 >= {1'b0, dvs2_q})};
      rem1_q <= (rsh1 >= {1'b0, dvs1_q}) ? rsh1 - {1'b0, dvs1_q} : rsh1;
      rem2_q <= (rsh2 >= {1'b0, dvs2_q}) ? rsh2 - {1'b0, dvs2_q} : rsh2;
      dcnt_q <= dcnt_q - 1'b1;
    end
  end

  // remainder stays below divisor, so one extra bit holds the shifted value
  assign rsh1 = {rem1_q[sbcs_pkg::USED_W-1:0], dvd1_q[sbcs_pkg::DVD_W-1]};
  assign rsh2 = {rem2_q[sbcs_pkg::USED_W-1:0], dvd2_q[sbcs_pkg::DVD_W-1]};
  assign stat_o.div_last = (dcnt_q == '0);

  // shell search: acc = (step*(k+1))^2 advanced by odd multiples of step^2
  logic [STW-1:0]     step;
  logic [2*STW-1:0]   step2_q;
  logic [CMPW-1:0]    acc_q, inc_q;
  logic [KW-1:0]      k_q;

  assign step = {shw_q, 1'b0};
  assign stat_o.shell_hit  = acc_q > CMPW'(r2);
  assign stat_o.shell_over = !stat_o.shell_hit && (k_q == LAST_K);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_step) begin
      step2_q <= step * step;
    end
    if (cmd_i.mul_row) begin
      sqr_q <= ar_q * ar_q;
      acc_q <= CMPW'(step2_q);
      inc_q <= CMPW'(step2_q) + CMPW'({step2_q, 1'b0});
      k_q   <= '0;
    end
    if (cmd_i.mul_col) begin
      sqc_q <= ac_q * ac_q;
    end
    if (cmd_i.shell_step && !stat_o.shell_hit && !stat_o.shell_over) begin
      acc_q <= acc_q + inc_q;
      inc_q <= inc_q + CMPW'({step2_q, 1'b0});
      k_q   <= k_q + 1'b1;
    end
  end

  // averages and products
  logic [sbcs_pkg::AVG_W-1:0] avg1, avg2;
  logic [2*sbcs_pkg::AVG_W-1:0] p11_q, p22_q, p12_q;

  assign avg1 = (dvd1_q[sbcs_pkg::DVD_W-1:sbcs_pkg::AVG_W] != '0) ? AVG_MAX
              : dvd1_q[sbcs_pkg::AVG_W-1:0];
  assign avg2 = (dvd2_q[sbcs_pkg::DVD_W-1:sbcs_pkg::AVG_W] != '0) ? AVG_MAX
              : dvd2_q[sbcs_pkg::AVG_W-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.sq_a) p11_q <= avg1 * avg1;
    if (cmd_i.sq_b) p22_q <= avg2 * avg2;
    if (cmd_i.sq_c) p12_q <= avg1 * avg2;
  end

  // bins
  logic [sbcs_pkg::CNT_W-1:0] cnt_q [NUM_BINS];
  logic [sbcs_pkg::SUM_W-1:0] s1_q  [NUM_BINS];
  logic [sbcs_pkg::SUM_W-1:0] s2_q  [NUM_BINS];
  logic [sbcs_pkg::SQ_W-1:0]  q1_q  [NUM_BINS];
  logic [sbcs_pkg::SQ_W-1:0]  q2_q  [NUM_BINS];
  logic [sbcs_pkg::SQ_W-1:0]  x_q   [NUM_BINS];

  logic [sbcs_pkg::SUM_W:0] s1n, s2n;
  logic [sbcs_pkg::SQ_W:0]  q1n, q2n, xn;

  assign s1n = {1'b0, s1_q[k_q]} + (sbcs_pkg::SUM_W + 1)'(avg1);
  assign s2n = {1'b0, s2_q[k_q]} + (sbcs_pkg::SUM_W + 1)'(avg2);
  assign q1n = {1'b0, q1_q[k_q]} + (sbcs_pkg::SQ_W + 1)'(p11_q);
  assign q2n = {1'b0, q2_q[k_q]} + (sbcs_pkg::SQ_W + 1)'(p22_q);
  assign xn  = {1'b0, x_q[k_q]}  + (sbcs_pkg::SQ_W + 1)'(p12_q);

  logic bin_clr;
  assign bin_clr = accept_i && (action_i == sbcs_pkg::ACT_CLEAR);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_BINS; i++) begin
        cnt_q[i] <= '0; s1_q[i] <= '0; s2_q[i] <= '0;
        q1_q[i] <= '0; q2_q[i] <= '0; x_q[i] <= '0;
      end
    end else if (bin_clr) begin
      for (int i = 0; i < NUM_BINS; i++) begin
        cnt_q[i] <= '0; s1_q[i] <= '0; s2_q[i] <= '0;
        q1_q[i] <= '0; q2_q[i] <= '0; x_q[i] <= '0;
      end
    end else if (cmd_i.update) begin
      cnt_q[k_q] <= (cnt_q[k_q] == CNT_MAX) ? CNT_MAX : cnt_q[k_q] + 1'b1;
      s1_q[k_q]  <= s1n[sbcs_pkg::SUM_W] ? SUM_MAX : s1n[sbcs_pkg::SUM_W-1:0];
      s2_q[k_q]  <= s2n[sbcs_pkg::SUM_W] ? SUM_MAX : s2n[sbcs_pkg::SUM_W-1:0];
      q1_q[k_q]  <= q1n[sbcs_pkg::SQ_W] ? SQ_MAX : q1n[sbcs_pkg::SQ_W-1:0];
      q2_q[k_q]  <= q2n[sbcs_pkg::SQ_W] ? SQ_MAX : q2n[sbcs_pkg::SQ_W-1:0];
      x_q[k_q]   <= xn[sbcs_pkg::SQ_W] ? SQ_MAX : xn[sbcs_pkg::SQ_W-1:0];
    end
  end

  // read port
  logic rd_go, rd_in;
  logic [KW-1:0] rd_idx;
  logic done_q;

  assign rd_go  = accept_i && (action_i == sbcs_pkg::ACT_READ);
  assign rd_in  = 32'(bin_select_i) < NUM_BINS;
  assign rd_idx = KW'(bin_select_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= rd_go;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_go) begin
      pair_count_o    <= rd_in ? cnt_q[rd_idx] : '0;
      sum_first_o     <= rd_in ? s1_q[rd_idx]  : '0;
      sum_second_o    <= rd_in ? s2_q[rd_idx]  : '0;
      sum_sq_first_o  <= rd_in ? q1_q[rd_idx]  : '0;
      sum_sq_second_o <= rd_in ? q2_q[rd_idx]  : '0;
      sum_cross_o     <= rd_in ? x_q[rd_idx]   : '0;
    end
  end

  assign done_o = done_q;

endmodule

// ===== src/shell_binned_correlation_sums_core.sv =====
// Top level: shell-binned correlation sums, controller plus datapath.
//
//  channel   | handshake                  | payload
//  ----------+----------------------------+-----------------------------------------
//  command   | start_i, busy_o            | action_i, pixels, inside flags, offsets,
//            |                            | chunk_end_i, bin_select_i
//  result    | done_o (one-cycle strobe)  | pair_count_o, sums, squares, cross
//  config    | cfg_valid_i, cfg_ready_o   | cfg_index_i, cfg_data_i
//
// A read, a clear or a pair that starts no finish takes one beat; busy_o stays low.
// A read shows its result with done_o in the cycle after the beat.
// A chunk-end pair whose both sides kept pixels, with nonzero shell width, runs the
// finish sequencer, busy_o high: step, row and column multiplies, the shell search;
// on a shell hit, the divider (one quotient bit per cycle), squares and bin update.
// Reset clears config to defaults, chunk accumulators and all bins at once.
// The result side has no backpressure; cfg_ready_o is always high.
module shell_binned_correlation_sums_core #(
  parameter int unsigned NUM_BINS = sbcs_pkg::NUM_BINS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [1:0]                        action_i,
  input  logic [sbcs_pkg::PIX_W-1:0]        pixel_first_i,
  input  logic [sbcs_pkg::PIX_W-1:0]        pixel_second_i,
  input  logic                              inside_first_i,
  input  logic                              inside_second_i,
  input  logic signed [sbcs_pkg::OFS_W-1:0] chunk_row_offset_i,
  input  logic signed [sbcs_pkg::OFS_W-1:0] chunk_col_offset_i,
  input  logic                              chunk_end_i,
  input  logic [sbcs_pkg::SEL_W-1:0]        bin_select_i,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [sbcs_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [sbcs_pkg::CFG_DAT_W-1:0]    cfg_data_i,
  output logic                              done_o,
  output logic [sbcs_pkg::CNT_W-1:0]        pair_count_o,
  output logic [sbcs_pkg::SUM_W-1:0]        sum_first_o,
  output logic [sbcs_pkg::SUM_W-1:0]        sum_second_o,
  output logic [sbcs_pkg::SQ_W-1:0]         sum_sq_first_o,
  output logic [sbcs_pkg::SQ_W-1:0]         sum_sq_second_o,
  output logic [sbcs_pkg::SQ_W-1:0]         sum_cross_o
);

  sbcs_pkg::cmd_t  cmd;
  sbcs_pkg::stat_t stat;
  logic accept;

  assign busy_o      = cmd.busy;
  assign accept      = start_i && !cmd.busy;
  assign cfg_ready_o = 1'b1;

  sbcs_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  sbcs_dp #(
    .NUM_BINS (NUM_BINS)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .accept_i           (accept),
    .action_i           (action_i),
    .pixel_first_i      (pixel_first_i),
    .pixel_second_i     (pixel_second_i),
    .inside_first_i     (inside_first_i),
    .inside_second_i    (inside_second_i),
    .chunk_row_offset_i (chunk_row_offset_i),
    .chunk_col_offset_i (chunk_col_offset_i),
    .chunk_end_i        (chunk_end_i),
    .bin_select_i       (bin_select_i),
    .cfg_we_i           (cfg_valid_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .cmd_i              (cmd),
    .stat_o             (stat),
    .done_o             (done_o),
    .pair_count_o       (pair_count_o),
    .sum_first_o        (sum_first_o),
    .sum_second_o       (sum_second_o),
    .sum_sq_first_o     (sum_sq_first_o),
    .sum_sq_second_o    (sum_sq_second_o),
    .sum_cross_o        (sum_cross_o)
  );

endmodule

// ===== src/sbcs_checker.sv =====
// Checker: port-level properties of the core, bound to the top level.
module sbcs_checker #(
  parameter int unsigned NUM_BINS = sbcs_pkg::NUM_BINS_DEF
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           start_i,
  input logic                           busy_o,
  input logic [1:0]                     action_i,
  input logic [sbcs_pkg::SEL_W-1:0]     bin_select_i,
  input logic                           done_o,
  input logic [sbcs_pkg::CNT_W-1:0]     pair_count_o,
  input logic [sbcs_pkg::SQ_W-1:0]      sum_cross_o
);

  logic rd_beat;
  assign rd_beat = start_i && !busy_o && (action_i == sbcs_pkg::ACT_READ);

  a_read_gives_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_beat |=> done_o) else $error("read beat without result");

  a_done_only_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(rd_beat)) else $error("result without read beat");

  a_read_past_bins_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_beat && (32'(bin_select_i) >= NUM_BINS)) |=>
    (pair_count_o == '0 && sum_cross_o == '0)) else $error("out-of-range read not zero");

  a_clear_no_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (action_i != sbcs_pkg::ACT_PAIR)) |=> !busy_o)
    else $error("busy after read or clear");

endmodule

bind shell_binned_correlation_sums_core sbcs_checker #(
  .NUM_BINS (NUM_BINS)
) u_sbcs_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start_i      (start_i),
  .busy_o       (busy_o),
  .action_i     (action_i),
  .bin_select_i (bin_select_i),
  .done_o       (done_o),
  .pair_count_o (pair_count_o),
  .sum_cross_o  (sum_cross_o)
);

// ===== dv/tb.sv =====
// Testbench for the shell-binned correlation sums core: predictor plus scoreboard.
module tb;

  localparam int NBINS = int'(sbcs_pkg::NUM_BINS_DEF);
  // Worst finish pass: multiplies, every shell searched, the full divide, squares and update.
  localparam int DRAIN_CYC = 80;
  localparam int WDOG_LIMIT = 20000;

  typedef struct packed {
    logic [1:0]  act;
    logic [15:0] p1;
    logic [15:0] p2;
    logic        in1;
    logic        in2;
    logic [13:0] row;
    logic [13:0] col;
    logic        cend;
    logic [4:0]  sel;
  } cmd_beat_t;

  typedef struct packed {
    logic [23:0] cnt;
    logic [47:0] s1;
    logic [47:0] s2;
    logic [63:0] q1;
    logic [63:0] q2;
    logic [63:0] qx;
  } bin_read_t;

  logic clk, rst_n;
  logic start, busy, done, cfg_valid, cfg_ready;
  logic [1:0] action;
  logic [15:0] pix1, pix2;
  logic ins1, ins2, cend;
  logic signed [13:0] rowo, colo;
  logic [4:0] sel;
  logic [2:0] cfg_idx;
  logic [15:0] cfg_dat;
  logic [23:0] o_cnt;
  logic [47:0] o_s1, o_s2;
  logic [63:0] o_q1, o_q2, o_qx;

  shell_binned_correlation_sums_core dut (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_o(busy),
    .action_i(action), .pixel_first_i(pix1), .pixel_second_i(pix2),
    .inside_first_i(ins1), .inside_second_i(ins2),
    .chunk_row_offset_i(rowo), .chunk_col_offset_i(colo),
    .chunk_end_i(cend), .bin_select_i(sel),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_idx), .cfg_data_i(cfg_dat),
    .done_o(done), .pair_count_o(o_cnt), .sum_first_o(o_s1),
    .sum_second_o(o_s2), .sum_sq_first_o(o_q1), .sum_sq_second_o(o_q2),
    .sum_cross_o(o_qx)
  );

  // Predictor state: its own copy of config, chunk accumulators and bins.
  logic [6:0]  m_box;
  logic [11:0] m_shw;
  logic [15:0] m_ovl1, m_ign1, m_ovl2, m_ign2;
  logic [27:0] m_tot1, m_tot2;
  logic [12:0] m_used1, m_used2;
  bin_read_t   m_bins [NBINS];

  cmd_beat_t pending_cmds[$];
  bin_read_t expected_reads[$];
  int  send_idle_pct;
  bit  hold_send;
  int  mismatches, watchdog;

  function automatic logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b,
                                          logic [63:0] cap);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > {1'b0, cap}) ? cap : s[63:0];
  endfunction

  function automatic logic [23:0] chunk_avg(logic [27:0] tot, logic [12:0] used);
    logic [35:0] q;
    q = {tot, 8'd0} / used;
    return (q > 36'hFFFFFF) ? 24'hFFFFFF : q[23:0];
  endfunction

  // Close a chunk: pick the shell from the chunk-end offsets and fold in.
  task automatic close_chunk(logic [13:0] row, logic [13:0] col);
    longint dr, dc, r2, stp, kk;
    int k;
    logic [23:0] a1, a2;
    if (m_used1 == 0 || m_used2 == 0 || m_shw == 0) return;
    dr = 2 * longint'($signed(row)) + longint'(m_box) - 1;
    dc = 2 * longint'($signed(col)) + longint'(m_box) - 1;
    r2 = dr * dr + dc * dc;
    stp = 2 * longint'(m_shw);
    if ((stp * NBINS) * (stp * NBINS) <= r2) return;
    k = 0;
    kk = 1;
    while (k + 1 < NBINS && (stp * kk) * (stp * kk) <= r2) begin
      k++;
      kk++;
    end
    a1 = chunk_avg(m_tot1, m_used1);
    a2 = chunk_avg(m_tot2, m_used2);
    m_bins[k].cnt = 24'(sat_sum(64'(m_bins[k].cnt), 64'd1, 64'hFFFFFF));
    m_bins[k].s1 = 48'(sat_sum(64'(m_bins[k].s1), 64'(a1), 64'hFFFF_FFFF_FFFF));
    m_bins[k].s2 = 48'(sat_sum(64'(m_bins[k].s2), 64'(a2), 64'hFFFF_FFFF_FFFF));
    m_bins[k].q1 = sat_sum(m_bins[k].q1, 64'(a1) * 64'(a1), '1);
    m_bins[k].q2 = sat_sum(m_bins[k].q2, 64'(a2) * 64'(a2), '1);
    m_bins[k].qx = sat_sum(m_bins[k].qx, 64'(a1) * 64'(a2), '1);
  endtask

  task automatic predict_beat(cmd_beat_t c);
    bin_read_t r;
    case (sbcs_pkg::action_e'(c.act))
      sbcs_pkg::ACT_PAIR: begin
        if (c.in1 && c.p1 != m_ovl1 && c.p1 != m_ign1) begin
          m_tot1 = 28'(sat_sum(64'(m_tot1), 64'(c.p1), 64'hFFFFFFF));
          m_used1 = 13'(sat_sum(64'(m_used1), 64'd1, 64'h1FFF));
        end
        if (c.in2 && c.p2 != m_ovl2 && c.p2 != m_ign2) begin
          m_tot2 = 28'(sat_sum(64'(m_tot2), 64'(c.p2), 64'hFFFFFFF));
          m_used2 = 13'(sat_sum(64'(m_used2), 64'd1, 64'h1FFF));
        end
        if (c.cend) begin
          close_chunk(c.row, c.col);
          m_tot1 = 0; m_used1 = 0; m_tot2 = 0; m_used2 = 0;
        end
      end
      sbcs_pkg::ACT_READ: begin
        r = '0;
        if (c.sel < NBINS) r = m_bins[c.sel];
        expected_reads.push_back(r);
      end
      sbcs_pkg::ACT_CLEAR: foreach (m_bins[i]) m_bins[i] = '0;
      default: ;
    endcase
  endtask

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Driver: a beat is taken at an edge with start high and busy low.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        predict_beat({action, pix1, pix2, ins1, ins2, rowo, colo, cend, sel});
      end
      if (!(start && busy)) begin
        if (pending_cmds.size() > 0 && !hold_send &&
            $urandom_range(99) >= send_idle_pct) begin
          cmd_beat_t c;
          c = pending_cmds.pop_front();
          start <= 1'b1;
          {action, pix1, pix2, ins1, ins2, rowo, colo, cend, sel} <= c;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: done_o is a one-cycle strobe, sampled at the edge.
  always @(posedge clk) begin
    if (rst_n && done) begin
      bin_read_t got, exp_r;
      got = {o_cnt, o_s1, o_s2, o_q1, o_q2, o_qx};
      if (expected_reads.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected read result %h", got);
      end else begin
        exp_r = expected_reads.pop_front();
        if (got !== exp_r) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"ERROR: read mismatch cnt %0d/%0d s1 %0h/%0h s2 %0h/%0h",
                      " q1 %0h/%0h q2 %0h/%0h x %0h/%0h"},
                     exp_r.cnt, got.cnt, exp_r.s1, got.s1, exp_r.s2, got.s2,
                     exp_r.q1, got.q1, exp_r.q2, got.q2, exp_r.qx, got.qx);
        end
      end
    end
  end

  // Watchdog: cycles with no beat taken, no result seen and no config write.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || done || cfg_valid) watchdog <= 0;
    else watchdog <= watchdog + 1;
    if (watchdog > WDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic cfg_write(sbcs_pkg::cfg_reg_e idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_idx <= idx;
    cfg_dat <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      sbcs_pkg::REG_BOX_SIZE:    m_box = val[6:0];
      sbcs_pkg::REG_SHELL_WIDTH: m_shw = val[11:0];
      sbcs_pkg::REG_OVL_FIRST:   m_ovl1 = val;
      sbcs_pkg::REG_IGN_FIRST:   m_ign1 = val;
      sbcs_pkg::REG_OVL_SECOND:  m_ovl2 = val;
      default:                   m_ign2 = val;
    endcase
  endtask

  // Wait for the driver to empty and every read to come back, then drain.
  task automatic settle();
    while (pending_cmds.size() > 0 || start || busy || expected_reads.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  function automatic cmd_beat_t pair_beat(logic [15:0] a, logic [15:0] b,
                                          logic e, int r, int c);
    cmd_beat_t x;
    x = '0;
    x.act = sbcs_pkg::ACT_PAIR;
    x.p1 = a; x.p2 = b; x.in1 = 1'b1; x.in2 = 1'b1; x.cend = e;
    x.row = 14'(r); x.col = 14'(c);
    return x;
  endfunction

  function automatic cmd_beat_t read_beat(int b);
    cmd_beat_t x;
    x = '0;
    x.act = sbcs_pkg::ACT_READ;
    x.sel = 5'(b);
    return x;
  endfunction

  // Random chunk: mostly well-formed pixel runs ending in a chunk end.
  task automatic queue_chunk(int maxlen, int tagv);
    cmd_beat_t x;
    int n, rng;
    n = $urandom_range(maxlen, 1);
    rng = $urandom_range(3);
    for (int i = 0; i < n; i++) begin
      x = '0;
      x.act = ($urandom_range(30) == 0) ? sbcs_pkg::ACT_NONE : sbcs_pkg::ACT_PAIR;
      x.p1 = $urandom_range(9) == 0 ? 16'(tagv) : 16'($urandom);
      x.p2 = $urandom_range(9) == 0 ? 16'hFFFF : 16'($urandom);
      x.in1 = $urandom_range(7) != 0;
      x.in2 = $urandom_range(7) != 0;
      x.row = (rng == 0) ? 14'($urandom) : 14'($signed(14'($urandom_range(600))) - 300);
      x.col = (rng == 0) ? 14'($urandom) : 14'($signed(14'($urandom_range(600))) - 300);
      x.cend = (i == n - 1);
      x.sel = 5'($urandom);
      pending_cmds.push_back(x);
    end
    if ($urandom_range(3) == 0) pending_cmds.push_back(read_beat($urandom_range(31)));
  endtask

  task automatic dump_bins();
    for (int b = 0; b < 32; b++) pending_cmds.push_back(read_beat(b));
  endtask

  initial begin
    cmd_beat_t x;
    rst_n = 0; start = 0; cfg_valid = 0; cfg_idx = '0; cfg_dat = '0;
    action = '0; pix1 = '0; pix2 = '0; ins1 = 0; ins2 = 0; rowo = '0; colo = '0;
    cend = 0; sel = '0; hold_send = 0; send_idle_pct = 20; mismatches = 0;
    watchdog = 0;
    m_box = 8; m_shw = 50; m_ovl1 = 16'hFFFF; m_ign1 = 16'hFFFE;
    m_ovl2 = 16'hFFFF; m_ign2 = 16'hFFFE;
    m_tot1 = 0; m_tot2 = 0; m_used1 = 0; m_used2 = 0;
    foreach (m_bins[i]) m_bins[i] = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: extremes, tags, empty sides, far shells, reads past bins.
    pending_cmds.push_back(pair_beat(16'hFFFF, 16'h0000, 0, 0, 0)); // overload
    pending_cmds.push_back(pair_beat(16'hFFFD, 16'h0001, 1, 0, 0));
    pending_cmds.push_back(pair_beat(16'hFFFE, 16'h1234, 1, 3, -4)); // empty side
    pending_cmds.push_back(pair_beat(16'h0000, 16'hFFFD, 1, -4096, -4096)); // beyond
    pending_cmds.push_back(pair_beat(16'h5555, 16'hAAAA, 1, 4095, -4096));
    pending_cmds.push_back(pair_beat(16'h00FF, 16'h7F00, 1, 100, 200));
    x = pair_beat(16'hAAAA, 16'h5555, 1, -8192, 8191); x.in1 = 1'b0;
    pending_cmds.push_back(x);
    x = '0; x.act = sbcs_pkg::ACT_NONE; x.sel = 5'h1F; x.p1 = '1; x.p2 = '1;
    x.in1 = 1'b1; x.in2 = 1'b1; x.cend = 1'b1; x.row = '1; x.col = '1;
    pending_cmds.push_back(x);
    pending_cmds.push_back(read_beat(0));
    pending_cmds.push_back(read_beat(3));
    pending_cmds.push_back(read_beat(24));
    pending_cmds.push_back(read_beat(25));
    pending_cmds.push_back(read_beat(31));
    x = '0; x.act = sbcs_pkg::ACT_CLEAR; pending_cmds.push_back(x);
    pending_cmds.push_back(read_beat(0));
    settle();

    // Extreme settings: large box, widest and narrowest shells, zero width, tags.
    cfg_write(sbcs_pkg::REG_BOX_SIZE, 16'd64);
    cfg_write(sbcs_pkg::REG_SHELL_WIDTH, 16'd1);
    cfg_write(sbcs_pkg::REG_OVL_FIRST, 16'd0);
    cfg_write(sbcs_pkg::REG_IGN_FIRST, 16'h8000);
    cfg_write(sbcs_pkg::REG_OVL_SECOND, 16'h7FFF);
    cfg_write(sbcs_pkg::REG_IGN_SECOND, 16'd0);
    for (int i = 0; i < 40; i++) queue_chunk(4, 16'h8000);
    dump_bins();
    settle();
    cfg_write(sbcs_pkg::REG_SHELL_WIDTH, 16'd0);
    cfg_write(sbcs_pkg::REG_BOX_SIZE, 16'd1);
    for (int i = 0; i < 10; i++) queue_chunk(3, 0);
    dump_bins();
    settle();
    cfg_write(sbcs_pkg::REG_SHELL_WIDTH, 16'd4095);
    cfg_write(sbcs_pkg::REG_BOX_SIZE, 16'd127);
    for (int i = 0; i < 20; i++) queue_chunk(6, 0);
    dump_bins();
    settle();

    // Random phases: sender idle 20%, then 82%, then no idling.
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 20 : (ph == 1) ? 82 : 0;
      cfg_write(sbcs_pkg::REG_BOX_SIZE, 16'($urandom_range(64, 1)));
      cfg_write(sbcs_pkg::REG_SHELL_WIDTH, 16'($urandom_range(60, 1)));
      cfg_write(sbcs_pkg::REG_IGN_FIRST, 16'hFFFE);
      cfg_write(sbcs_pkg::REG_OVL_FIRST, 16'hFFFF);
      x = '0; x.act = sbcs_pkg::ACT_CLEAR; pending_cmds.push_back(x);
      while (pending_cmds.size() < 220) queue_chunk(12, 16'hFFFE);
      dump_bins();
      // Hold off once until all reads are back, then continue.
      while (pending_cmds.size() > 150) @(posedge clk);
      hold_send = 1;
      while (expected_reads.size() > 0 || busy) @(posedge clk);
      hold_send = 0;
      settle();
    end

    if (mismatches == 0 && expected_reads.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
